// File: design/q2r_pkg.sv
// Shared constants for the quaternion to rotation matrix block.
package q2r_pkg;

    localparam int ENTRY_WIDTH = 16;
    localparam int MAT_ENTRIES = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

endpackage

// File: design/quaternion_to_rotation_matrix_core.sv
// Top level of the quaternion to rotation matrix converter.
// Usage:
// The input channel takes one quaternion word (quat_x, quat_y, quat_z, quat_w)
// when in_valid is high and in_stall is low. The output channel offers the
// nine matrix entries and zero_magnitude under out_valid and out_stall.
// Entries carry FRACTION_BITS fraction bits, rounded to nearest with ties away
// from zero. An all-zero quaternion gives zero entries with zero_magnitude set.
// One word is accepted per cycle and one result leaves per cycle while
// out_stall is low. From the accepting edge to out_valid the word passes the
// product register, which loads at the accepting edge, then the queue,
// FRACTION_BITS + 2 divider stages that each settle one quotient bit in all
// nine dividers, and the output register.
// A two-word queue separates the front end from the divider line, so the
// front keeps accepting while the back waits on out_stall. When the receiver
// stalls, the divider line holds and the output word stays unchanged; in_stall
// rises once the queue and the front register are full.
// Reset clears all valid flags; no word is in flight after reset.
module quaternion_to_rotation_matrix_core #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS = 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COMPONENT_WIDTH-1:0]  quat_x,
    input  logic signed [COMPONENT_WIDTH-1:0]  quat_y,
    input  logic signed [COMPONENT_WIDTH-1:0]  quat_z,
    input  logic signed [COMPONENT_WIDTH-1:0]  quat_w,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [q2r_pkg::ENTRY_WIDTH-1:0] m00,
    output logic signed [q2r_pkg::ENTRY_WIDTH-1:0] m01,
    output logic signed [q2r_pkg::ENTRY_WIDTH-1:0] m02,
    output logic signed [q2r_pkg::ENTRY_WIDTH-1:0] m10,
    output logic signed [q2r_pkg::ENTRY_WIDTH-1:0] m11,
    output logic signed [q2r_pkg::ENTRY_WIDTH-1:0] m12,
    output logic signed [q2r_pkg::ENTRY_WIDTH-1:0] m20,
    output logic signed [q2r_pkg::ENTRY_WIDTH-1:0] m21,
    output logic signed [q2r_pkg::ENTRY_WIDTH-1:0] m22,
    output logic                               zero_magnitude
);

    localparam int MW = 2 * COMPONENT_WIDTH + 1;
    localparam int WW = (q2r_pkg::MAT_ENTRIES + 1) * MW + q2r_pkg::MAT_ENTRIES + 1;

    logic          push_valid, push_ready, pop_valid, pop_ready;
    logic [WW-1:0] push_data, pop_data;
    logic [q2r_pkg::MAT_ENTRIES-1:0][q2r_pkg::ENTRY_WIDTH-1:0] entries;

    q2r_front #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH),
        .MAG_WIDTH(MW),
        .WORD_WIDTH(WW)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .quat_x(quat_x),
        .quat_y(quat_y),
        .quat_z(quat_z),
        .quat_w(quat_w),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data(push_data)
    );

    q2r_queue #(
        .WORD_WIDTH(WW)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data(push_data),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_data(pop_data)
    );

    q2r_back #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH),
        .FRACTION_BITS(FRACTION_BITS),
        .MAG_WIDTH(MW),
        .WORD_WIDTH(WW)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_data(pop_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .entries(entries),
        .zero_magnitude(zero_magnitude)
    );

    assign m00 = entries[0];
    assign m01 = entries[1];
    assign m02 = entries[2];
    assign m10 = entries[3];
    assign m11 = entries[4];
    assign m12 = entries[5];
    assign m20 = entries[6];
    assign m21 = entries[7];
    assign m22 = entries[8];

endmodule

// File: design/q2r_front.sv
// Front end: products of the components, magnitude and the nine numerators.
module q2r_front #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int MAG_WIDTH = 2 * COMPONENT_WIDTH + 1,
    parameter int WORD_WIDTH = 10 * MAG_WIDTH + 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_x,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_y,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_z,
    input  logic signed [COMPONENT_WIDTH-1:0] quat_w,
    output logic                              push_valid,
    input  logic                              push_ready,
    output logic [WORD_WIDTH-1:0]             push_data
);

    localparam int PW = 2 * COMPONENT_WIDTH;
    localparam int NW = 2 * COMPONENT_WIDTH + 3;
    localparam int NE = q2r_pkg::MAT_ENTRIES;

    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [PW-1:0] xy_reg, xz_reg, xw_reg, yz_reg, yw_reg, zw_reg;
    logic                 valid_reg;
    logic                 load;

    logic signed [NW-1:0] exx, eyy, ezz, eww, exy, exz, exw, eyz, eyw, ezw;
    logic signed [NW-1:0] msum;
    logic signed [NW-1:0] num [NE];
    logic signed [NW-1:0] absn [NE];
    logic [NE-1:0]              neg;
    logic [NE*MAG_WIDTH-1:0]    mags;

    assign load       = !valid_reg || push_ready;
    assign in_stall   = !load;
    assign push_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            ww_reg <= quat_w * quat_w;
            xy_reg <= quat_x * quat_y;
            xz_reg <= quat_x * quat_z;
            xw_reg <= quat_x * quat_w;
            yz_reg <= quat_y * quat_z;
            yw_reg <= quat_y * quat_w;
            zw_reg <= quat_z * quat_w;
        end
    end

    always_comb
    begin
        exx = NW'(xx_reg);
        eyy = NW'(yy_reg);
        ezz = NW'(zz_reg);
        eww = NW'(ww_reg);
        exy = NW'(xy_reg);
        exz = NW'(xz_reg);
        exw = NW'(xw_reg);
        eyz = NW'(yz_reg);
        eyw = NW'(yw_reg);
        ezw = NW'(zw_reg);
        msum = exx + eyy + ezz + eww;
        num[0] = (exx + eww) - (eyy + ezz);
        num[1] = (exy + ezw) <<< 1;
        num[2] = (exz - eyw) <<< 1;
        num[3] = (exy - ezw) <<< 1;
        num[4] = (eyy + eww) - (exx + ezz);
        num[5] = (eyz + exw) <<< 1;
        num[6] = (exz + eyw) <<< 1;
        num[7] = (eyz - exw) <<< 1;
        num[8] = (ezz + eww) - (exx + eyy);
        for (int i = 0; i < NE; i++)
        begin
            neg[i]  = num[i][NW-1];
            absn[i] = neg[i] ? -num[i] : num[i];
            mags[i*MAG_WIDTH +: MAG_WIDTH] = absn[i][MAG_WIDTH-1:0];
        end
        push_data = {(msum == '0), msum[MAG_WIDTH-1:0], neg, mags};
    end

endmodule

// File: design/q2r_queue.sv
// Short queue of classified words between the front end and the dividers.
module q2r_queue #(
    parameter int WORD_WIDTH = 340
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  logic [WORD_WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output logic [WORD_WIDTH-1:0] pop_data
);

    localparam int DEPTH = q2r_pkg::QUEUE_DEPTH;

    logic [WORD_WIDTH-1:0]                mem_reg [DEPTH];
    logic [q2r_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [q2r_pkg::QUEUE_CNT_WIDTH-1:0] count_reg, count_next;
    logic                                 push, pop;

    assign push_ready = count_reg != q2r_pkg::QUEUE_CNT_WIDTH'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == q2r_pkg::QUEUE_PTR_WIDTH'(DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == q2r_pkg::QUEUE_PTR_WIDTH'(DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/q2r_back.sv
// Back end: nine pipelined restoring dividers, rounding and the output register.
module q2r_back #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS = 14,
    parameter int MAG_WIDTH = 2 * COMPONENT_WIDTH + 1,
    parameter int WORD_WIDTH = 10 * MAG_WIDTH + 10
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    pop_valid,
    output logic                                    pop_ready,
    input  logic [WORD_WIDTH-1:0]                   pop_data,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [q2r_pkg::MAT_ENTRIES-1:0][q2r_pkg::ENTRY_WIDTH-1:0] entries,
    output logic                                    zero_magnitude
);

    localparam int NE = q2r_pkg::MAT_ENTRIES;
    localparam int EW = q2r_pkg::ENTRY_WIDTH;
    localparam int QW = FRACTION_BITS + 2;
    localparam int RW = MAG_WIDTH + FRACTION_BITS + 1;
    localparam int XW = (QW > EW) ? QW : EW;

    logic                 adv;
    logic                 v_reg    [QW];
    logic                 zero_reg [QW];
    logic [MAG_WIDTH-1:0] m_reg    [QW];
    logic [NE-1:0]        neg_reg  [QW];
    logic [RW-1:0]        rem_reg  [QW][NE];
    logic [QW-1:0]        q_reg    [QW][NE];

    logic                 in_zero;
    logic [MAG_WIDTH-1:0] in_m;
    logic [NE-1:0]        in_neg;
    logic [NE*MAG_WIDTH-1:0] in_mags;

    logic                 out_valid_reg;
    logic                 zero_out_reg;
    logic [NE-1:0][EW-1:0] entries_reg;

    // The whole divider line moves together whenever the output word can move.
    assign adv       = !out_valid_reg || !out_stall;
    assign pop_ready = adv;
    assign {in_zero, in_m, in_neg, in_mags} = pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QW; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= pop_valid;
            for (int s = 1; s < QW; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            out_valid_reg <= v_reg[QW-1];
        end
    end

    // Stage s settles quotient bit QW-1-s against the divisor shifted by that much.
    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [MAG_WIDTH-1:0] m_in;
        logic [RW-1:0]        rem_in  [NE];
        logic [QW-1:0]        q_in    [NE];
        logic [RW-1:0]        dv;
        logic [RW-1:0]        rem_out [NE];
        logic [QW-1:0]        q_out   [NE];
        logic                 zero_in;
        logic [NE-1:0]        neg_in;

        always_comb
        begin
            if (s == 0)
            begin
                m_in    = in_m;
                zero_in = in_zero;
                neg_in  = in_neg;
                for (int i = 0; i < NE; i++)
                begin
                    rem_in[i] = {in_mags[i*MAG_WIDTH +: MAG_WIDTH],
                                 {(FRACTION_BITS + 1){1'b0}}};
                    q_in[i]   = '0;
                end
            end
            else
            begin
                m_in    = m_reg[(s == 0) ? 0 : s-1];
                zero_in = zero_reg[(s == 0) ? 0 : s-1];
                neg_in  = neg_reg[(s == 0) ? 0 : s-1];
                for (int i = 0; i < NE; i++)
                begin
                    rem_in[i] = rem_reg[(s == 0) ? 0 : s-1][i];
                    q_in[i]   = q_reg[(s == 0) ? 0 : s-1][i];
                end
            end
            dv = {{(RW - MAG_WIDTH){1'b0}}, m_in} << (QW - 1 - s);
            for (int i = 0; i < NE; i++)
            begin
                if (rem_in[i] >= dv)
                begin
                    rem_out[i] = rem_in[i] - dv;
                    q_out[i]   = {q_in[i][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_out[i] = rem_in[i];
                    q_out[i]   = {q_in[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m_reg[s]    <= m_in;
                zero_reg[s] <= zero_in;
                neg_reg[s]  <= neg_in;
                for (int i = 0; i < NE; i++)
                begin
                    rem_reg[s][i] <= rem_out[i];
                    q_reg[s][i]   <= q_out[i];
                end
            end
        end
    end

    logic [QW-1:0] rnd [NE];
    logic [XW-1:0] mag_x [NE];
    logic [XW-1:0] val_x [NE];
    logic [NE-1:0][EW-1:0] entries_next;

    // Round half away from zero on the magnitude, clamp to one, then apply the sign.
    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            rnd[i] = (q_reg[QW-1][i] + 1'b1) >> 1;
            if (rnd[i] > (QW'(1) << FRACTION_BITS))
            begin
                rnd[i] = QW'(1) << FRACTION_BITS;
            end
            mag_x[i] = XW'(rnd[i]);
            val_x[i] = neg_reg[QW-1][i] ? -mag_x[i] : mag_x[i];
            entries_next[i] = zero_reg[QW-1] ? '0 : val_x[i][EW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            entries_reg  <= entries_next;
            zero_out_reg <= zero_reg[QW-1];
        end
    end

    assign out_valid      = out_valid_reg;
    assign entries        = entries_reg;
    assign zero_magnitude = zero_out_reg;

endmodule

// File: design/q2r_checker.sv
// Port-level checks for the quaternion to rotation matrix converter.
module q2r_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [q2r_pkg::ENTRY_WIDTH-1:0]    m00,
    input logic [q2r_pkg::ENTRY_WIDTH-1:0]    m01,
    input logic [q2r_pkg::ENTRY_WIDTH-1:0]    m02,
    input logic [q2r_pkg::ENTRY_WIDTH-1:0]    m10,
    input logic [q2r_pkg::ENTRY_WIDTH-1:0]    m11,
    input logic [q2r_pkg::ENTRY_WIDTH-1:0]    m12,
    input logic [q2r_pkg::ENTRY_WIDTH-1:0]    m20,
    input logic [q2r_pkg::ENTRY_WIDTH-1:0]    m21,
    input logic [q2r_pkg::ENTRY_WIDTH-1:0]    m22,
    input logic                               zero_magnitude
);

    // No word may appear while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output word offered during reset");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled output word dropped");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(m00) && $stable(m11) && $stable(m22)
            && $stable(m01) && $stable(zero_magnitude))
        else $error("stalled output word changed");

    // A zero quaternion must come out as an all-zero matrix.
    a_zero_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_magnitude |-> (m00 == '0) && (m01 == '0) && (m02 == '0)
            && (m10 == '0) && (m11 == '0) && (m12 == '0) && (m20 == '0)
            && (m21 == '0) && (m22 == '0))
        else $error("zero quaternion gave nonzero entries");

endmodule

bind quaternion_to_rotation_matrix_core q2r_checker u_q2r_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .m00(m00),
    .m01(m01),
    .m02(m02),
    .m10(m10),
    .m11(m11),
    .m12(m12),
    .m20(m20),
    .m21(m21),
    .m22(m22),
    .zero_magnitude(zero_magnitude)
);
